// File: sv/pmi_pkg.sv
// shared types, constants and helpers for the particle motion integrator
`default_nettype none
package pmi_pkg;

  // shared multiplier operand and product widths
  localparam int MulAW  = 33;
  localparam int MulBW  = 33;
  localparam int ProdW  = MulAW + MulBW;

  // exp2 polynomial coefficients, Q16
  localparam logic [17:0] ExpC1  = 18'd45559;
  localparam logic [17:0] ExpC2  = 18'd14819;
  localparam logic [17:0] ExpC3  = 18'd5179;
  localparam logic [17:0] ExpOne = 18'd65536;

  // register reset values
  localparam logic [30:0]        InvMassReset = 31'd65536;
  localparam logic signed [20:0] LogDampReset = -21'sd950;
  localparam logic [30:0]        LifeReset    = 31'd327680;

  // operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_FORCE  = 2'd0,
    OP_STEP   = 2'd1,
    OP_LAUNCH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_INV_MASS  = 3'd0,
    REG_LOG_DAMP  = 3'd1,
    REG_IMMOVABLE = 3'd2,
    REG_ANCHORED  = 3'd3,
    REG_ANCHOR_X  = 3'd4,
    REG_ANCHOR_Y  = 3'd5,
    REG_ANCHOR_Z  = 3'd6,
    REG_INIT_LIFE = 3'd7
  } reg_idx_e;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [82:0] x);
    logic signed [82:0] hi;
    logic signed [82:0] lo;
    hi = 83'sd2147483647;
    lo = -83'sd2147483648;
    if (x > hi) return 32'sh7fffffff;
    else if (x < lo) return 32'sh80000000;
    else return x[31:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/particle_motion_integrator_top.sv
// particle motion integrator: state, sequencer and configuration registers
// add force, launch and unused codes: the post state, then the output register holds the result
// time step: 20 products through one shared multiplier, then the post state
// immovable step: goes straight to the post state; one transaction in flight, next accepted when idle
// the output register holds a result while the next transaction is accepted
// asynchronous active-low reset loads register and particle reset values
`default_nettype none
module particle_motion_integrator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [31:0] vector_x_i,
  input  wire logic [31:0] vector_y_i,
  input  wire logic [31:0] vector_z_i,
  input  wire logic [31:0] launch_accel_y_i,
  input  wire logic [23:0] time_step_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      position_x_o,
  output logic [31:0]      position_y_o,
  output logic [31:0]      position_z_o,
  output logic [31:0]      velocity_x_o,
  output logic [31:0]      velocity_y_o,
  output logic [31:0]      velocity_z_o,
  output logic [31:0]      life_remaining_o,
  output logic             destroyed_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import pmi_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_POST} st_e;

  typedef enum logic [3:0] {
    CL_TT, CL_E, CL_VT, CL_H, CL_AT, CL_FA, CL_DV, CL_VM, CL_NOP
  } cls_e;

  typedef struct packed {
    cls_e       cls;
    logic [1:0] ax;
  } uop_t;

  localparam logic [4:0] LastIssue = 5'd19;
  localparam logic [4:0] LastCycle = 5'd20;

  // micro-op schedule, producers at least two slots ahead of consumers
  function automatic uop_t uop_of(input logic [4:0] idx);
    uop_t u;
    u = '{cls: CL_NOP, ax: 2'd0};
    unique case (idx)
      5'd0:  u = '{cls: CL_TT, ax: 2'd0};
      5'd1:  u = '{cls: CL_E,  ax: 2'd0};
      5'd2:  u = '{cls: CL_VT, ax: 2'd0};
      5'd3:  u = '{cls: CL_H,  ax: 2'd0};
      5'd4:  u = '{cls: CL_VT, ax: 2'd1};
      5'd5:  u = '{cls: CL_H,  ax: 2'd1};
      5'd6:  u = '{cls: CL_VT, ax: 2'd2};
      5'd7:  u = '{cls: CL_H,  ax: 2'd2};
      5'd8:  u = '{cls: CL_AT, ax: 2'd0};
      5'd9:  u = '{cls: CL_AT, ax: 2'd1};
      5'd10: u = '{cls: CL_AT, ax: 2'd2};
      5'd11: u = '{cls: CL_FA, ax: 2'd0};
      5'd12: u = '{cls: CL_FA, ax: 2'd1};
      5'd13: u = '{cls: CL_FA, ax: 2'd2};
      5'd14: u = '{cls: CL_DV, ax: 2'd0};
      5'd15: u = '{cls: CL_DV, ax: 2'd1};
      5'd16: u = '{cls: CL_DV, ax: 2'd2};
      5'd17: u = '{cls: CL_VM, ax: 2'd0};
      5'd18: u = '{cls: CL_VM, ax: 2'd1};
      5'd19: u = '{cls: CL_VM, ax: 2'd2};
      default: u = '{cls: CL_NOP, ax: 2'd0};
    endcase
    return u;
  endfunction

  // velocity times 2^n after the mantissa product
  function automatic logic signed [31:0] damp(input logic signed [50:0] pr,
                                              input logic signed [12:0] n);
    logic signed [13:0] s;
    logic signed [13:0] kk;
    logic [5:0]         sh;
    logic [4:0]         k;
    logic signed [82:0] w;
    w = 83'(pr);
    if (n <= 13'sd16) begin
      s  = 14'sd16 - 14'(n);
      sh = (s > 14'sd63) ? 6'd63 : s[5:0];
      w  = w >>> sh;
    end else begin
      kk = 14'(n) - 14'sd16;
      k  = (kk > 14'sd31) ? 5'd31 : kk[4:0];
      w  = w <<< k;
    end
    return sat32(w);
  endfunction

  // configuration registers
  logic [30:0]        inv_mass_q;
  logic signed [20:0] log_damp_q;
  logic               immovable_q;
  logic               anchored_q;
  logic signed [31:0] anchor_x_q, anchor_y_q, anchor_z_q;
  logic [30:0]        init_life_q;

  // particle state
  logic signed [31:0] pos_q [3];
  logic signed [31:0] vel_q [3];
  logic signed [31:0] acc_q [3];
  logic signed [31:0] frc_q [3];
  logic signed [31:0] life_q;
  logic               dst_q;

  // sequencer and step temporaries
  st_e                st_q;
  logic [4:0]         cnt_q;
  logic               wb_vld_q;
  logic [4:0]         wb_idx_q;
  logic [23:0]        t_q;
  logic [31:0]        tt_q;
  logic signed [12:0] n_q;
  logic [15:0]        f_q;
  logic [17:0]        hp_q;
  logic signed [40:0] pacc_q [3];
  logic signed [40:0] addend_q;

  // output register
  logic               out_vld_q;
  logic [31:0]        out_pos_q [3];
  logic [31:0]        out_vel_q [3];
  logic [31:0]        out_life_q;
  logic               out_dst_q;

  uop_t               iss, wbu;
  logic               issue;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [40:0]      addend_d;
  logic signed [ProdW-1:0] prod;
  logic signed [31:0]      wb_val;
  logic signed [40:0]      pacc_d;
  logic [17:0]             hp_d;
  logic signed [31:0]      life_d;
  logic signed [31:0]      vec [3];
  logic                    in_acc;
  logic                    out_load;
  logic                    cfg_wr;
  reg_idx_e                cfg_idx;

  assign in_ready_o = (st_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_load   = (st_q == ST_POST) && (!out_vld_q || out_ready_i);
  assign issue      = (st_q == ST_RUN) && (cnt_q <= LastIssue);
  assign iss        = uop_of(cnt_q);
  assign wbu        = uop_of(wb_idx_q);
  assign vec[0]     = vector_x_i;
  assign vec[1]     = vector_y_i;
  assign vec[2]     = vector_z_i;
  assign cfg_wr     = psel & penable & pwrite & pready;
  assign cfg_idx    = reg_idx_e'(paddr[4:2]);
  assign pready     = 1'b1;

  // operand selection for the shared multiplier
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    addend_d = '0;
    case (iss.cls)
      CL_TT: begin
        mul_a = {9'b0, t_q};
        mul_b = {9'b0, t_q};
      end
      CL_E: begin
        mul_a = 33'(log_damp_q);
        mul_b = {9'b0, t_q};
      end
      CL_VT: begin
        mul_a    = 33'(vel_q[iss.ax]);
        mul_b    = {9'b0, t_q};
        addend_d = 41'(pos_q[iss.ax]);
      end
      CL_H: begin
        mul_a = {15'b0, hp_q};
        mul_b = {17'b0, f_q};
      end
      CL_AT: begin
        mul_a    = 33'(acc_q[iss.ax]);
        mul_b    = {1'b0, tt_q};
        addend_d = pacc_q[iss.ax];
      end
      CL_FA: begin
        mul_a    = 33'(frc_q[iss.ax]);
        mul_b    = {2'b0, inv_mass_q};
        addend_d = 41'(acc_q[iss.ax]);
      end
      CL_DV: begin
        mul_a    = 33'(acc_q[iss.ax]);
        mul_b    = {9'b0, t_q};
        addend_d = 41'(vel_q[iss.ax]);
      end
      CL_VM: begin
        mul_a = 33'(vel_q[iss.ax]);
        mul_b = {15'b0, hp_q};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  pmi_mul u_mul (
    .clk_i (clk_i),
    .en_i  (issue),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // write-back arithmetic on the registered product
  always_comb begin
    pacc_d = addend_q + 41'($signed(prod[55:16]));
    hp_d   = ExpOne + prod[33:16];
    wb_val = '0;
    case (wbu.cls)
      CL_H: begin
        if (wbu.ax == 2'd0) hp_d = ExpC2 + prod[33:16];
        else if (wbu.ax == 2'd1) hp_d = ExpC1 + prod[33:16];
      end
      CL_AT: wb_val = sat32(83'(addend_q) + 83'($signed(prod[63:17])));
      CL_FA: wb_val = sat32(83'(addend_q) + 83'($signed(prod[62:16])));
      CL_DV: wb_val = sat32(83'(addend_q) + 83'($signed(prod[55:16])));
      CL_VM: wb_val = damp(prod[50:0], n_q);
      default: wb_val = '0;
    endcase
    life_d = sat32(83'(life_q) - 83'(t_q));
  end

  // register read data
  always_comb begin
    unique case (cfg_idx)
      REG_INV_MASS:  prdata = {1'b0, inv_mass_q};
      REG_LOG_DAMP:  prdata = 32'(log_damp_q);
      REG_IMMOVABLE: prdata = {31'b0, immovable_q};
      REG_ANCHORED:  prdata = {31'b0, anchored_q};
      REG_ANCHOR_X:  prdata = anchor_x_q;
      REG_ANCHOR_Y:  prdata = anchor_y_q;
      REG_ANCHOR_Z:  prdata = anchor_z_q;
      REG_INIT_LIFE: prdata = {1'b0, init_life_q};
      default:       prdata = '0;
    endcase
  end

  // sequencer, state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_mass_q  <= InvMassReset;
      log_damp_q  <= LogDampReset;
      immovable_q <= 1'b0;
      anchored_q  <= 1'b0;
      anchor_x_q  <= '0;
      anchor_y_q  <= '0;
      anchor_z_q  <= '0;
      init_life_q <= LifeReset;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
        acc_q[i] <= '0;
        frc_q[i] <= '0;
      end
      life_q    <= 32'(LifeReset);
      dst_q     <= 1'b0;
      st_q      <= ST_IDLE;
      cnt_q     <= '0;
      wb_vld_q  <= 1'b0;
      wb_idx_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_INV_MASS:  inv_mass_q  <= pwdata[30:0];
          REG_LOG_DAMP:  log_damp_q  <= pwdata[20:0];
          REG_IMMOVABLE: immovable_q <= pwdata[0];
          REG_ANCHORED:  anchored_q  <= pwdata[0];
          REG_ANCHOR_X:  anchor_x_q  <= pwdata;
          REG_ANCHOR_Y:  anchor_y_q  <= pwdata;
          REG_ANCHOR_Z:  anchor_z_q  <= pwdata;
          REG_INIT_LIFE: init_life_q <= pwdata[30:0];
          default:       init_life_q <= init_life_q;
        endcase
      end

      // output handshake
      if (out_load) out_vld_q <= 1'b1;
      else if (out_vld_q && out_ready_i) out_vld_q <= 1'b0;

      wb_vld_q <= issue;
      wb_idx_q <= cnt_q;
      if (issue) addend_q <= addend_d;

      unique case (st_q)
        ST_IDLE: begin
          if (in_acc) begin
            st_q  <= (op_e'(operation_i) == OP_STEP && !immovable_q) ? ST_RUN : ST_POST;
            t_q   <= time_step_i;
            cnt_q <= '0;
            hp_q  <= ExpC3;
            case (op_e'(operation_i))
              OP_FORCE: begin
                for (int i = 0; i < 3; i++) begin
                  frc_q[i] <= sat32(83'(frc_q[i]) + 83'(vec[i]));
                end
              end
              OP_LAUNCH: begin
                for (int i = 0; i < 3; i++) begin
                  vel_q[i] <= vec[i];
                  acc_q[i] <= (i == 1) ? launch_accel_y_i : '0;
                  frc_q[i] <= '0;
                end
                pos_q[0] <= anchor_x_q;
                pos_q[1] <= anchor_y_q;
                pos_q[2] <= anchor_z_q;
                life_q   <= 32'(init_life_q);
                dst_q    <= 1'b0;
              end
              default: begin
                dst_q <= dst_q;
              end
            endcase
          end
        end
        ST_RUN: begin
          cnt_q <= cnt_q + 5'd1;
          // product write-back
          if (wb_vld_q) begin
            case (wbu.cls)
              CL_TT: tt_q <= prod[47:16];
              CL_E: begin
                n_q <= prod[44:32];
                f_q <= prod[31:16];
              end
              CL_VT: pacc_q[wbu.ax] <= pacc_d;
              CL_H:  hp_q <= hp_d;
              CL_AT: pos_q[wbu.ax] <= wb_val;
              CL_FA: acc_q[wbu.ax] <= wb_val;
              CL_DV, CL_VM: vel_q[wbu.ax] <= wb_val;
              default: hp_q <= hp_q;
            endcase
          end
          // end of step: life, clearing and anchor pinning
          if (cnt_q == LastCycle) begin
            st_q   <= ST_POST;
            life_q <= life_d;
            if (life_d <= 32'sd0) dst_q <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              acc_q[i] <= '0;
              frc_q[i] <= '0;
            end
            if (anchored_q) begin
              pos_q[0] <= anchor_x_q;
              pos_q[1] <= anchor_y_q;
              vel_q[0] <= '0;
              vel_q[1] <= '0;
            end
          end
        end
        ST_POST: begin
          if (out_load) begin
            for (int i = 0; i < 3; i++) begin
              out_pos_q[i] <= pos_q[i];
              out_vel_q[i] <= vel_q[i];
            end
            out_life_q <= life_q;
            out_dst_q  <= dst_q;
            st_q       <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_vld_q;
  assign position_x_o     = out_pos_q[0];
  assign position_y_o     = out_pos_q[1];
  assign position_z_o     = out_pos_q[2];
  assign velocity_x_o     = out_vel_q[0];
  assign velocity_y_o     = out_vel_q[1];
  assign velocity_z_o     = out_vel_q[2];
  assign life_remaining_o = out_life_q;
  assign destroyed_o      = out_dst_q;

`ifndef SYNTHESIS
  // the sequencer never runs past the final step cycle
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RUN) |-> (cnt_q <= LastCycle))
    else $error("step counter overrun");

  // a write-back always follows an issue in the previous cycle
  a_wb_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_vld_q |-> $past(issue))
    else $error("write-back without issue");

  // destroyed only sets at the end of a step
  a_dst_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(dst_q) |-> $past(st_q == ST_RUN))
    else $error("destroyed set outside a step");

  // an accepted transaction always leaves idle
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (st_q != ST_IDLE))
    else $error("accepted transaction not taken up");
`endif

endmodule
`default_nettype wire

// File: sv/pmi_mul.sv
// shared registered signed multiplier
`default_nettype none
module pmi_mul (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic signed [pmi_pkg::MulAW-1:0]  a_i,
  input  wire logic signed [pmi_pkg::MulBW-1:0]  b_i,
  output logic signed [pmi_pkg::ProdW-1:0]       p_o
);
  import pmi_pkg::*;

  logic signed [ProdW-1:0] p_q;

  // product register, held while idle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// File: tb/pmi_checker.sv
// checker for the particle motion integrator: predicts and compares results
`timescale 1ns / 1ps
module pmi_checker
  import pmi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  operation_i,
  input  logic [31:0] vector_x_i,
  input  logic [31:0] vector_y_i,
  input  logic [31:0] vector_z_i,
  input  logic [31:0] launch_accel_y_i,
  input  logic [23:0] time_step_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] position_x_i,
  input  logic [31:0] position_y_i,
  input  logic [31:0] position_z_i,
  input  logic [31:0] velocity_x_i,
  input  logic [31:0] velocity_y_i,
  input  logic [31:0] velocity_z_i,
  input  logic [31:0] life_remaining_i,
  input  logic        destroyed_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] px, py, pz, vx, vy, vz, life;
    logic        dead;
  } snapshot_t;

  // particle and register copies
  logic [30:0]        inv_mass;
  logic signed [20:0] log_damp;
  logic               immov, anch;
  logic signed [31:0] anc_x, anc_y, anc_z;
  logic [30:0]        init_life;
  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] acc [3];
  logic signed [31:0] frc [3];
  logic signed [31:0] life;
  logic               dead;
  snapshot_t          expected_q [$];

  assign pending_o = expected_q.size();

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] x);
    if (x > 128'sd2147483647) return 32'sh7fffffff;
    if (x < -128'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // velocity times 2^e with cubic fraction approximation
  function automatic logic signed [31:0] damp(input logic signed [31:0] v,
                                              input longint n, input longint f);
    longint p, m, s;
    logic signed [127:0] prod;
    p = ExpC3;
    p = ExpC2 + ((p * f) >>> 16);
    p = ExpC1 + ((p * f) >>> 16);
    m = 65536 + ((p * f) >>> 16);
    prod = 128'(v) * 128'(m);
    if (n <= 16) begin
      s = 16 - n;
      if (s > 63) s = 63;
      return clamp32(prod >>> s);
    end
    if (prod == 0) return 0;
    if (n - 16 > 30) return prod > 0 ? 32'sh7fffffff : 32'sh80000000;
    if (prod > 128'sd4294967296) prod = 128'sd4294967296;
    if (prod < -128'sd4294967296) prod = -128'sd4294967296;
    return clamp32(prod <<< (n - 16));
  endfunction

  task automatic integrate(input logic [23:0] t);
    logic signed [127:0] tt, ts, e;
    longint n, f;
    ts = 128'(t);
    tt = (ts * ts) >>> 16;
    for (int i = 0; i < 3; i++)
      pos[i] = clamp32(128'(pos[i]) + ((128'(pos[i]) * 0) + ((128'(vel[i]) * ts) >>> 16))
                       + ((128'(acc[i]) * tt) >>> 17));
    e = (128'(log_damp) * ts) >>> 16;
    n = longint'(e >>> 16);
    f = longint'(e & 128'hffff);
    for (int i = 0; i < 3; i++) begin
      acc[i] = clamp32(128'(acc[i]) + ((128'(frc[i]) * $signed({1'b0, inv_mass})) >>> 16));
      vel[i] = clamp32(128'(vel[i]) + ((128'(acc[i]) * ts) >>> 16));
      vel[i] = damp(vel[i], n, f);
    end
    life = clamp32(128'(life) - ts);
    if (life <= 0) dead = 1'b1;
    for (int i = 0; i < 3; i++) begin
      frc[i] = '0;
      acc[i] = '0;
    end
    if (anch) begin
      pos[0] = anc_x;
      pos[1] = anc_y;
      vel[0] = '0;
      vel[1] = '0;
    end
  endtask

  // predict on accepted input, compare on accepted output
  always @(posedge clk_i or negedge rst_ni) begin
    snapshot_t got, want;
    logic signed [31:0] vec [3];
    if (!rst_ni) begin
      inv_mass = InvMassReset; log_damp = LogDampReset; immov = 0; anch = 0;
      anc_x = 0; anc_y = 0; anc_z = 0; init_life = LifeReset;
      for (int i = 0; i < 3; i++) begin
        pos[i] = 0; vel[i] = 0; acc[i] = 0; frc[i] = 0;
      end
      life = $signed({1'b0, LifeReset}); dead = 0;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[4:2]))
          REG_INV_MASS:  inv_mass = pwdata[30:0];
          REG_LOG_DAMP:  log_damp = pwdata[20:0];
          REG_IMMOVABLE: immov = pwdata[0];
          REG_ANCHORED:  anch = pwdata[0];
          REG_ANCHOR_X:  anc_x = pwdata;
          REG_ANCHOR_Y:  anc_y = pwdata;
          REG_ANCHOR_Z:  anc_z = pwdata;
          REG_INIT_LIFE: init_life = pwdata[30:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = '{position_x_i, position_y_i, position_z_i, velocity_x_i,
                velocity_y_i, velocity_z_i, life_remaining_i, destroyed_i};
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (got != want) fail_count_o++;
          if (got.px != want.px) $error("position_x exp %h got %h", want.px, got.px);
          if (got.py != want.py) $error("position_y exp %h got %h", want.py, got.py);
          if (got.pz != want.pz) $error("position_z exp %h got %h", want.pz, got.pz);
          if (got.vx != want.vx) $error("velocity_x exp %h got %h", want.vx, got.vx);
          if (got.vy != want.vy) $error("velocity_y exp %h got %h", want.vy, got.vy);
          if (got.vz != want.vz) $error("velocity_z exp %h got %h", want.vz, got.vz);
          if (got.life != want.life)
            $error("life_remaining exp %h got %h", want.life, got.life);
          if (got.dead != want.dead)
            $error("destroyed exp %b got %b", want.dead, got.dead);
        end
      end
      if (in_valid_i && in_ready_i) begin
        vec[0] = vector_x_i; vec[1] = vector_y_i; vec[2] = vector_z_i;
        case (op_e'(operation_i))
          OP_FORCE:
            for (int i = 0; i < 3; i++) frc[i] = clamp32(128'(frc[i]) + 128'(vec[i]));
          OP_STEP:
            if (!immov) integrate(time_step_i);
          OP_LAUNCH: begin
            for (int i = 0; i < 3; i++) begin
              vel[i] = vec[i]; acc[i] = 0; frc[i] = 0;
            end
            acc[1] = launch_accel_y_i;
            pos[0] = anc_x; pos[1] = anc_y; pos[2] = anc_z;
            life = $signed({1'b0, init_life});
            dead = 0;
          end
          default: ;
        endcase
        want = '{pos[0], pos[1], pos[2], vel[0], vel[1], vel[2], life, dead};
        expected_q.insert(expected_q.size(), want);
      end
    end
  end

endmodule

// File: tb/testbench.sv
// stimulus and verdict for the particle motion integrator
`timescale 1ns / 1ps
module testbench;
  import pmi_pkg::*;

  logic        clk_i = 0, rst_ni = 0;
  logic        in_valid_i = 0, out_ready_i = 0;
  logic [1:0]  operation_i = '0;
  logic [31:0] vector_x_i = '0, vector_y_i = '0, vector_z_i = '0, launch_accel_y_i = '0;
  logic [23:0] time_step_i = '0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic        in_ready_o, out_valid_o, destroyed_o, pready;
  logic [31:0] position_x_o, position_y_o, position_z_o;
  logic [31:0] velocity_x_o, velocity_y_o, velocity_z_o, life_remaining_o, prdata;
  int          fail_count, pending;
  int          send_idle_pct = 25, recv_idle_pct = 72;
  bit          hold_off = 0;
  int          step_count = 0, launch_count = 0;

  particle_motion_integrator_top DUT (.*);

  pmi_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .operation_i,
    .vector_x_i, .vector_y_i, .vector_z_i, .launch_accel_y_i, .time_step_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .position_x_i(position_x_o), .position_y_i(position_y_o),
    .position_z_i(position_z_o), .velocity_x_i(velocity_x_o),
    .velocity_y_i(velocity_y_o), .velocity_z_i(velocity_z_o),
    .life_remaining_i(life_remaining_o), .destroyed_i(destroyed_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // clock
  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // run limit
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver with random stalls and one long hold-off
  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] data);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= data;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk_i);
  endtask

  // drop valid, wait for all results, then let the block settle
  task automatic drain;
    in_valid_i <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // valid stays high after acceptance until an idle cycle or the next transaction
  task automatic send(input op_e op, input logic [31:0] x, y, z, ay,
                      input logic [23:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; operation_i <= op;
    vector_x_i <= x; vector_y_i <= y; vector_z_i <= z;
    launch_accel_y_i <= ay; time_step_i <= t;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    if (op == OP_STEP) step_count++;
    if (op == OP_LAUNCH) launch_count++;
  endtask

  function automatic logic [31:0] rnd_vec();
    case ($urandom_range(4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [23:0] rnd_time();
    case ($urandom_range(5))
      0: return 24'hffffff;
      1: return 24'($urandom());
      default: return 24'($urandom_range(8000));
    endcase
  endfunction

  task automatic random_burst(input int count);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(19))
        0, 1, 2: send(OP_LAUNCH, rnd_vec(), rnd_vec(), rnd_vec(), rnd_vec(),
                      24'($urandom()));
        3, 4, 5, 6, 7: send(OP_FORCE, rnd_vec(), rnd_vec(), rnd_vec(), $urandom(),
                             24'($urandom()));
        8: send(OP_NONE, $urandom(), $urandom(), $urandom(), $urandom(),
                24'($urandom()));
        default: send(OP_STEP, $urandom(), $urandom(), $urandom(), $urandom(), rnd_time());
      endcase
    end
  endtask

  task automatic random_config(input int mode);
    reg_write(REG_INV_MASS, mode == 0 ? 32'h7fffffff : mode == 1 ? 32'h0 :
              32'($urandom_range(262144)));
    reg_write(REG_LOG_DAMP, mode == 0 ? 32'hfff00000 : mode == 1 ? 32'h0 :
              32'(-$signed($urandom_range(1048576))));
    reg_write(REG_IMMOVABLE, 32'($urandom_range(5) == 0));
    reg_write(REG_ANCHORED, 32'($urandom_range(3) == 0));
    reg_write(REG_ANCHOR_X, mode == 0 ? 32'h80000000 : $urandom());
    reg_write(REG_ANCHOR_Y, mode == 0 ? 32'h7fffffff : $urandom());
    reg_write(REG_ANCHOR_Z, $urandom());
    reg_write(REG_INIT_LIFE, mode == 1 ? 32'h7fffffff : mode == 0 ? 32'h0 :
              $urandom_range(1500000));
  endtask

  // stimulus
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    repeat (2) @(posedge clk_i);

    // directed: reset config, every operation and edge values
    send(OP_NONE, '1, '1, '1, '1, '1);
    send(OP_FORCE, 32'h7fffffff, 32'h80000000, 32'h00010000, '0, '0);
    send(OP_FORCE, 32'h7fffffff, 32'h80000000, '1, '0, '0);
    send(OP_STEP, '0, '0, '0, '0, 24'h010000);
    send(OP_LAUNCH, 32'h00050000, 32'hfffb0000, 32'h80000000, 32'hfff60000, '0);
    send(OP_STEP, '0, '0, '0, '0, 24'hffffff);
    send(OP_STEP, '0, '0, '0, '0, 24'hffffff);
    send(OP_STEP, '0, '0, '0, '0, '0);
    send(OP_FORCE, 32'h00010000, '0, '0, '0, '0);
    send(OP_STEP, '0, '0, '0, '0, 24'h000100);
    drain();
    // positive damping exponent, immovable and anchored
    reg_write(REG_LOG_DAMP, 32'h000fffff);
    send(OP_LAUNCH, 32'h00010000, 32'hffff0000, 32'h7fffffff, '0, '0);
    send(OP_STEP, '0, '0, '0, '0, 24'h000800);
    send(OP_STEP, '0, '0, '0, '0, 24'hffffff);
    drain();
    reg_write(REG_IMMOVABLE, 1);
    reg_write(REG_ANCHORED, 1);
    send(OP_STEP, '0, '0, '0, '0, 24'h010000);
    send(OP_FORCE, 32'h00020000, '0, '0, '0, '0);
    send(OP_LAUNCH, 32'h00030000, '0, '0, '0, '0);
    drain();
    reg_write(REG_IMMOVABLE, 0);
    send(OP_STEP, '0, '0, '0, '0, 24'h008000);
    drain();
    // very negative exponent
    reg_write(REG_LOG_DAMP, 32'hfff00000);
    reg_write(REG_ANCHORED, 0);
    send(OP_LAUNCH, 32'hffff0000, 32'h00010000, 32'h80000000, '0, '0);
    send(OP_STEP, '0, '0, '0, '0, 24'hffffff);
    drain();

    // random phases under each idling pattern
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin send_idle_pct = 72; recv_idle_pct = 25; end
      if (ph == 8) begin send_idle_pct = 0; recv_idle_pct = 0; end
      random_config(ph % 3);
      if (ph == 9) begin
        fork
          begin
            hold_off = 1;
            repeat (400) @(posedge clk_i);
            hold_off = 0;
          end
          random_burst(150);
        join
      end else
        random_burst(150);
      drain();
    end

    repeat (50) @(posedge clk_i);
    $display("covered %0d steps and %0d launches over 12 register settings",
             step_count, launch_count);
    $display("with random stalls on both sides and one long output hold-off");
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
